// File: rtl/aeske_pkg.sv
// ----------------------------------------------------------------------------
// aeske_pkg
// shared types, codes and tables for the aes-128 round key expander
// ----------------------------------------------------------------------------
package aeske_pkg;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_EXPAND = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [3:0]  round;
  } in_item_t;

  typedef struct packed {
    logic [63:0] round_key_high;
    logic [63:0] round_key_low;
  } out_item_t;

  // round key as four words, word 0 in the top bits
  typedef logic [3:0][31:0] key_words_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // round constant, zero outside rounds 1 to 10
  function automatic logic [7:0] rcon(input logic [3:0] round);
    logic [7:0] r;
    case (round)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/aeske_round_core.sv
// ----------------------------------------------------------------------------
// aeske_round_core
// next stored key for one item: load a cipher key or expand one round
// ----------------------------------------------------------------------------
module aeske_round_core (
  input  aeske_pkg::key_words_t key,
  input  aeske_pkg::in_item_t   item,
  output aeske_pkg::key_words_t key_next
);
  import aeske_pkg::*;

  logic [31:0] rot;
  logic [31:0] temp;
  key_words_t  expanded;

  // rotate word 3 left one byte, substitute, add rcon to the top byte
  assign rot = {key[0][23:0], key[0][31:24]};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      temp[i*8 +: 8] = SBOX[rot[i*8 +: 8]];
    end
    temp[31:24] = temp[31:24] ^ rcon(item.round);
  end

  // key[3] is word 0, key[0] is word 3
  always_comb begin
    expanded[3] = key[3] ^ temp;
    expanded[2] = key[2] ^ expanded[3];
    expanded[1] = key[1] ^ expanded[2];
    expanded[0] = key[0] ^ expanded[1];
  end

  always_comb begin
    case (item.op)
      OP_LOAD:   key_next = {item.key_high, item.key_low};
      OP_EXPAND: key_next = expanded;
      default:   key_next = expanded;
    endcase
  end

endmodule

// File: rtl/aes128_key_expand_round.sv
// ----------------------------------------------------------------------------
// aes128_key_expand_round
// aes-128 key schedule, one round key per transfer
// ----------------------------------------------------------------------------
// The block holds the current round key. A load transfer stores a new cipher
// key, an expand transfer with round 1 to 10 replaces the stored key with the
// next round key; every transfer returns the key as stored after it. An item
// passes through the input register, where the s-box lookups and the
// chained word xors run, and then sits in the output register until taken.
// One item is taken every clock as long as results are taken; the four
// parallel s-box lookups followed by the chain of four word xors in the
// input stage set the clock period.
module aes128_key_expand_round (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aeske_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aeske_pkg::out_item_t out_data
);
  import aeske_pkg::*;

  // input stage
  logic       stage_valid;
  in_item_t   stage_item;
  logic       advance;

  // stored round key, word 0 in the top bits
  key_words_t key;
  key_words_t key_next;

  aeske_round_core u_core (
    .key      (key),
    .item     (stage_item),
    .key_next (key_next)
  );

  // stage moves into the output register when that register is free or draining
  assign advance  = stage_valid && (!out_valid || !out_stall);
  // stage can take a new transfer when empty or moving on this cycle
  assign in_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_item <= in_data;
    end
  end

  // key state commits as the item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (advance) begin
      key <= key_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {key_next[3], key_next[2], key_next[1], key_next[0]};
    end
  end

endmodule
